### hdl/rss_pkg.sv
package rss_pkg;

  // Fixed field widths of the words on the ports.
  localparam int LABEL_W = 24;
  localparam int POS_W   = 20;
  localparam int HAP_W   = 2;
  localparam int ROWI_W  = 5;

  // Operation codes of an input word.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CROSS = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [HAP_W-1:0]   parent_hap;
    logic [ROWI_W-1:0]  row_index;
    logic [LABEL_W-1:0] row_label;
    logic [POS_W-1:0]   row_start;
    logic               row_is_last;
    logic               section_first;
    logic               section_last;
    logic [POS_W-1:0]   cross_start;
    logic [POS_W-1:0]   cross_end;
  } in_word_t;

  typedef struct packed {
    logic [LABEL_W-1:0] child_label;
    logic [POS_W-1:0]   child_start;
    logic               run_last;
    logic               search_error;
  } out_word_t;

  // Request and response between the sequencer and the search engine.
  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] site;
  } srch_req_t;

  typedef struct packed {
    logic done;
    logic found;
  } srch_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_START_E,
    ST_SRCH_S,
    ST_SRCH_E,
    ST_PREP,
    ST_HEAD,
    ST_EMIT,
    ST_ERR
  } core_state_t;

  typedef enum logic [2:0] {
    SR_IDLE,
    SR_FIRST,
    SR_LASTCHK,
    SR_LOOP,
    SR_MID,
    SR_SCAN
  } srch_state_t;

endpackage

### hdl/rss_search.sv
// Binary search for the rightmost table row whose start site is at or
// before a given site. One table row is probed at a time through the
// caller's memory read port, whose data arrives in the cycle after rd_row.
module rss_search #(
  parameter int MAX_SEGS = 32,
  parameter int POS_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rss_pkg::srch_req_t                req,
  input  logic [$clog2(MAX_SEGS+1)-1:0]     row_cnt,
  input  logic [((POS_BITS < rss_pkg::POS_W) ? POS_BITS : rss_pkg::POS_W)-1:0] rd_site,
  output logic [$clog2(MAX_SEGS)-1:0]       rd_row,
  output rss_pkg::srch_rsp_t                rsp,
  output logic [$clog2(MAX_SEGS)-1:0]       hit_row
);

  localparam int RW  = $clog2(MAX_SEGS);
  localparam int RCW = $clog2(MAX_SEGS + 1);
  localparam int PW  = rss_pkg::POS_W;

  rss_pkg::srch_state_t state_r, state_nxt;
  logic [PW-1:0] v_r, v_nxt;
  logic [RW-1:0] last_r, last_nxt;
  logic [RW-1:0] left_r, left_nxt;
  logic [RW-1:0] right_r, right_nxt;
  logic [RW-1:0] mid_r, mid_nxt;

  logic [PW-1:0] site_ext;
  logic          site_le;
  logic          site_eq;
  logic [RW:0]   mid_sum;
  logic [RW-1:0] mid_c;
  logic [RW-1:0] span;
  logic [RW-1:0] left_inc;

  // The one shared comparator: probed site against the search key.
  assign site_ext = PW'(rd_site);
  assign site_le  = (site_ext <= v_r);
  assign site_eq  = (site_ext == v_r);

  assign mid_sum  = {1'b0, left_r} + {1'b0, right_r};
  assign mid_c    = mid_sum[RW:1];
  assign span     = right_r - left_r;
  assign left_inc = left_r + RW'(1);

  // Search sequencer.
  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    last_nxt  = last_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    mid_nxt   = mid_r;
    rd_row    = '0;
    rsp       = '0;
    hit_row   = left_r;
    unique case (state_r)
      rss_pkg::SR_IDLE: begin
        rd_row = '0;
        if (req.start) begin
          v_nxt     = req.site;
          last_nxt  = RW'(row_cnt - RCW'(1));
          state_nxt = rss_pkg::SR_FIRST;
        end
      end
      rss_pkg::SR_FIRST: begin
        // Row 0 is on the read port; fetch the last row next.
        rd_row = last_r;
        if (!site_le) begin
          rsp.done  = 1'b1;
          rsp.found = 1'b0;
          state_nxt = rss_pkg::SR_IDLE;
        end else begin
          state_nxt = rss_pkg::SR_LASTCHK;
        end
      end
      rss_pkg::SR_LASTCHK: begin
        if (site_le) begin
          rsp.done  = 1'b1;
          rsp.found = 1'b1;
          hit_row   = last_r;
          state_nxt = rss_pkg::SR_IDLE;
        end else begin
          left_nxt  = '0;
          right_nxt = last_r;
          state_nxt = rss_pkg::SR_LOOP;
        end
      end
      rss_pkg::SR_LOOP: begin
        rd_row = mid_c;
        if (span > RW'(1)) begin
          mid_nxt   = mid_c;
          state_nxt = rss_pkg::SR_MID;
        end else begin
          rsp.done  = 1'b1;
          rsp.found = 1'b1;
          hit_row   = left_r;
          state_nxt = rss_pkg::SR_IDLE;
        end
      end
      rss_pkg::SR_MID: begin
        // Prefetch the row after mid in case an exact hit needs a scan.
        rd_row = mid_r + RW'(1);
        if (site_eq) begin
          left_nxt = mid_r;
          if (mid_r < last_r) begin
            state_nxt = rss_pkg::SR_SCAN;
          end else begin
            rsp.done  = 1'b1;
            rsp.found = 1'b1;
            hit_row   = mid_r;
            state_nxt = rss_pkg::SR_IDLE;
          end
        end else if (!site_le) begin
          right_nxt = mid_r;
          state_nxt = rss_pkg::SR_LOOP;
        end else begin
          left_nxt  = mid_r;
          state_nxt = rss_pkg::SR_LOOP;
        end
      end
      rss_pkg::SR_SCAN: begin
        // Walk forward over rows that start exactly at the key.
        rd_row = left_r + RW'(2);
        if (site_eq) begin
          left_nxt = left_inc;
          if (left_inc >= last_r) begin
            rsp.done  = 1'b1;
            rsp.found = 1'b1;
            hit_row   = left_inc;
            state_nxt = rss_pkg::SR_IDLE;
          end
        end else begin
          rsp.done  = 1'b1;
          rsp.found = 1'b1;
          hit_row   = left_r;
          state_nxt = rss_pkg::SR_IDLE;
        end
      end
      default: begin
        state_nxt = rss_pkg::SR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rss_pkg::SR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r     <= v_nxt;
    last_r  <= last_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
    mid_r   <= mid_nxt;
  end

endmodule

### hdl/recombinant_segment_splice_core.sv
// Channel  Direction  Payload               Handshake
// in_      input      rss_pkg::in_word_t    in_valid / in_stall
// out_     output     rss_pkg::out_word_t   out_valid / out_stall
//
// A load word is taken without stalling the input. After a crossover word the input stalls
// through a check state, a step before any end search, each search (first row probed, then
// the last row, then one halving probe after another, then a scan over equal-start rows; an
// end row can decide early), a prefetch, a head step unless first, and the emission of each
// word. The one memory read port and the one site comparator set this pace; output stalls slow it.
// Reset clears the sequencer, row counts and last label; rows are garbage until written.
module recombinant_segment_splice_core #(
  parameter int PARENT_HAPS = 4,
  parameter int MAX_SEGS    = 32,
  parameter int POS_BITS    = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rss_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rss_pkg::out_word_t out_data
);

  localparam int NH    = (PARENT_HAPS < 4) ? PARENT_HAPS : 4;
  localparam int HW    = (NH > 1) ? $clog2(NH) : 1;
  localparam int RW    = $clog2(MAX_SEGS);
  localparam int RCW   = $clog2(MAX_SEGS + 1);
  localparam int PW    = rss_pkg::POS_W;
  localparam int LW    = rss_pkg::LABEL_W;
  localparam int SW    = (POS_BITS < PW) ? POS_BITS : PW;
  localparam int DEPTH = NH * MAX_SEGS;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = LW + SW;

  rss_pkg::core_state_t state_r, state_nxt;
  rss_pkg::in_word_t    in_r, in_nxt;
  rss_pkg::out_word_t   out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ld;
  logic [RCW-1:0]       n_r, n_nxt;
  logic [RW-1:0]        s_r, s_nxt;
  logic [RW-1:0]        to_r, to_nxt;
  logic [RCW-1:0]       cur_r, cur_nxt;
  logic [LW-1:0]        last_lab_r, last_lab_nxt;
  logic [RCW-1:0]       row_cnt_r [NH];

  logic [MW-1:0]        mem [DEPTH];
  logic [MW-1:0]        rd_q_r;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic [RCW-1:0]       rd_row_sel;
  logic                 srch_sel;
  logic                 in_fire;
  logic                 load_ok;
  logic                 hap_ok;
  logic                 out_free;
  logic [LW-1:0]        rd_lab;
  logic [SW-1:0]        rd_site;
  logic [RCW-1:0]       to_ext;

  rss_pkg::srch_req_t   srch_req;
  rss_pkg::srch_rsp_t   srch_rsp;
  logic [RW-1:0]        srch_rd_row;
  logic [RW-1:0]        srch_hit;

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = (state_r != rss_pkg::ST_IDLE);
  assign load_ok  = (int'(in_data.parent_hap) < NH) && (int'(in_data.row_index) < MAX_SEGS);
  assign hap_ok   = (int'(in_r.parent_hap) < NH);
  assign out_free = !out_valid_r || !out_stall;
  assign rd_lab   = rd_q_r[MW-1:SW];
  assign rd_site  = rd_q_r[SW-1:0];
  assign to_ext   = RCW'(to_r);

  // Segment memory: one write port for loads, one registered read port.
  assign wr_addr = AW'(int'(in_data.parent_hap) * MAX_SEGS + int'(in_data.row_index));
  assign srch_sel = (state_r == rss_pkg::ST_CHECK) || (state_r == rss_pkg::ST_START_E) ||
                    (state_r == rss_pkg::ST_SRCH_S) || (state_r == rss_pkg::ST_SRCH_E);
  assign rd_row_sel = srch_sel ? RCW'(srch_rd_row) : cur_nxt;
  assign rd_addr = AW'(int'(in_r.parent_hap) * MAX_SEGS + int'(rd_row_sel));

  always_ff @(posedge clk) begin
    if (in_fire && (in_data.operation == rss_pkg::OP_LOAD) && load_ok) begin
      mem[wr_addr] <= {in_data.row_label, in_data.row_start[SW-1:0]};
    end
    rd_q_r <= mem[rd_addr];
  end

  // Row counts per parent table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int h = 0; h < NH; h++) begin
        row_cnt_r[h] <= '0;
      end
    end else if (in_fire && (in_data.operation == rss_pkg::OP_LOAD) && load_ok &&
                 in_data.row_is_last) begin
      row_cnt_r[in_data.parent_hap[HW-1:0]] <= RCW'(int'(in_data.row_index) + 1);
    end
  end

  rss_search #(
    .MAX_SEGS (MAX_SEGS),
    .POS_BITS (POS_BITS)
  ) u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (srch_req),
    .row_cnt (n_r),
    .rd_site (rd_site),
    .rd_row  (srch_rd_row),
    .rsp     (srch_rsp),
    .hit_row (srch_hit)
  );

  // Crossover sequencer: searches, head row handling, then row copy, or an error word.
  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    n_nxt         = n_r;
    s_nxt         = s_r;
    to_nxt        = to_r;
    cur_nxt       = cur_r;
    last_lab_nxt  = last_lab_r;
    out_ld        = 1'b0;
    out_nxt       = out_r;
    srch_req      = '0;
    unique case (state_r)
      rss_pkg::ST_IDLE: begin
        if (in_fire && (in_data.operation == rss_pkg::OP_CROSS)) begin
          in_nxt    = in_data;
          n_nxt     = row_cnt_r[in_data.parent_hap[HW-1:0]];
          state_nxt = rss_pkg::ST_CHECK;
        end
      end
      rss_pkg::ST_CHECK: begin
        if (!hap_ok || (n_r == '0)) begin
          state_nxt = rss_pkg::ST_ERR;
        end else if (in_r.section_first && in_r.section_last) begin
          cur_nxt   = '0;
          to_nxt    = RW'(n_r - RCW'(1));
          state_nxt = rss_pkg::ST_PREP;
        end else if (in_r.section_first) begin
          state_nxt = rss_pkg::ST_START_E;
        end else begin
          srch_req.start = 1'b1;
          srch_req.site  = in_r.cross_start;
          state_nxt      = rss_pkg::ST_SRCH_S;
        end
      end
      rss_pkg::ST_START_E: begin
        // A section end at site 0 searches below every row.
        if (in_r.cross_end == '0) begin
          state_nxt = rss_pkg::ST_ERR;
        end else begin
          srch_req.start = 1'b1;
          srch_req.site  = in_r.cross_end - PW'(1);
          state_nxt      = rss_pkg::ST_SRCH_E;
        end
      end
      rss_pkg::ST_SRCH_S: begin
        if (srch_rsp.done) begin
          if (!srch_rsp.found) begin
            state_nxt = rss_pkg::ST_ERR;
          end else begin
            s_nxt = srch_hit;
            if (in_r.section_last) begin
              to_nxt    = RW'(n_r - RCW'(1));
              cur_nxt   = RCW'(srch_hit);
              state_nxt = rss_pkg::ST_PREP;
            end else begin
              state_nxt = rss_pkg::ST_START_E;
            end
          end
        end
      end
      rss_pkg::ST_SRCH_E: begin
        if (srch_rsp.done) begin
          if (!srch_rsp.found) begin
            state_nxt = rss_pkg::ST_ERR;
          end else begin
            to_nxt    = srch_hit;
            cur_nxt   = in_r.section_first ? '0 : RCW'(s_r);
            state_nxt = rss_pkg::ST_PREP;
          end
        end
      end
      rss_pkg::ST_PREP: begin
        // The read of row cur is in flight.
        state_nxt = in_r.section_first ? rss_pkg::ST_EMIT : rss_pkg::ST_HEAD;
      end
      rss_pkg::ST_HEAD: begin
        if (rd_lab == last_lab_r) begin
          // Same founder as the last emitted segment: merge by skipping it.
          cur_nxt   = cur_r + RCW'(1);
          state_nxt = rss_pkg::ST_EMIT;
        end else if (PW'(rd_site) == in_r.cross_start) begin
          state_nxt = rss_pkg::ST_EMIT;
        end else if (out_free) begin
          // Crossover inside the row: open a split segment at the crossover.
          out_ld               = 1'b1;
          out_nxt.child_label  = rd_lab;
          out_nxt.child_start  = PW'(in_r.cross_start[SW-1:0]);
          out_nxt.run_last     = (cur_r >= to_ext);
          out_nxt.search_error = 1'b0;
          last_lab_nxt         = rd_lab;
          cur_nxt              = cur_r + RCW'(1);
          state_nxt            = (cur_r >= to_ext) ? rss_pkg::ST_IDLE : rss_pkg::ST_EMIT;
        end
      end
      rss_pkg::ST_EMIT: begin
        if (cur_r > to_ext) begin
          state_nxt = rss_pkg::ST_IDLE;
        end else if (out_free) begin
          out_ld               = 1'b1;
          out_nxt.child_label  = rd_lab;
          out_nxt.child_start  = PW'(rd_site);
          out_nxt.run_last     = (cur_r == to_ext);
          out_nxt.search_error = 1'b0;
          last_lab_nxt         = rd_lab;
          cur_nxt              = cur_r + RCW'(1);
          if (cur_r == to_ext) begin
            state_nxt = rss_pkg::ST_IDLE;
          end
        end
      end
      rss_pkg::ST_ERR: begin
        if (out_free) begin
          out_ld               = 1'b1;
          out_nxt.child_label  = '0;
          out_nxt.child_start  = '0;
          out_nxt.run_last     = 1'b1;
          out_nxt.search_error = 1'b1;
          state_nxt            = rss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rss_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rss_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      last_lab_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_lab_r  <= last_lab_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r  <= in_nxt;
    out_r <= out_nxt;
    n_r   <= n_nxt;
    s_r   <= s_nxt;
    to_r  <= to_nxt;
    cur_r <= cur_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### hdl/rss_checker.sv
module rss_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input rss_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input rss_pkg::out_word_t out_data
);

  // A stalled output word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // An error word is always the final word and carries no segment.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.search_error |->
      out_data.run_last && (out_data.child_label == '0) && (out_data.child_start == '0))
    else $error("malformed error word");

  // A crossover word keeps the input side busy in the following cycle.
  a_cross_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.operation == rss_pkg::OP_CROSS) |=> in_stall)
    else $error("input taken right after a crossover word");

  // A table load never produces a result word.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.operation == rss_pkg::OP_LOAD) && !out_valid
      |=> !out_valid)
    else $error("result word after a table load");

endmodule

bind recombinant_segment_splice_core rss_checker u_rss_checker (.*);
